[rtl/core/wof_pkg.sv]
// Shared types and constants for the window outlier interval filter.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package wof_pkg;

  localparam int START_W         = 31;
  localparam int SIZE_W          = 21;
  localparam int LEN_W           = 33;
  localparam int NUM_W           = 32;
  localparam int FACTOR_W        = 8;
  localparam int DROP_FACTOR     = 10;
  localparam int WINDOW_HALF_DEF = 3;
  localparam int WINDOW_HALF_MAX = 8;

  // Neighbor counts and sums are sized for the largest supported window.
  localparam int CNT_W  = $clog2(WINDOW_HALF_MAX + 1);
  localparam int SUM_W  = LEN_W + CNT_W;
  localparam int PROD_W = SUM_W + FACTOR_W + 1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(10);
  localparam logic [NUM_W-1:0]    NUM_RESET    = NUM_W'(1);

  // Register index carried in the upper address bit.
  localparam logic [ADDR_W-3:0] REG_OUTLIER_FACTOR = '0;

  // One pending decision handed from the window to the judge.
  typedef struct packed {
    logic                      valid;
    logic                      step_end;
    logic [START_W-1:0]        istart;
    logic [START_W-1:0]        iend;
    logic signed [LEN_W-1:0]   len;
    logic signed [SUM_W-1:0]   bsum;
    logic [CNT_W-1:0]          bcnt;
    logic signed [SUM_W-1:0]   asum;
    logic [CNT_W-1:0]          acnt;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [START_W-1:0]        kept_start;
    logic [START_W-1:0]        kept_end;
    logic signed [LEN_W-1:0]   kept_length;
    logic [NUM_W-1:0]          instance_number;
    logic                      run_last;
  } res_t;

endpackage

[rtl/core/wof_in_if.sv]
// Input channel of the window outlier interval filter: valid/ready plus one interval.
// Depends on wof_pkg for field widths.
`timescale 1ns / 1ps

interface wof_in_if;
  import wof_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] interval_start;
  logic [START_W-1:0] interval_end;
  logic [SIZE_W-1:0]  group_size;
  logic               group_last;

  modport source (output valid, output interval_start, output interval_end,
                  output group_size, output group_last, input ready);
  modport sink   (input valid, input interval_start, input interval_end,
                  input group_size, input group_last, output ready);
endinterface

[rtl/core/wof_out_if.sv]
// Result channel of the window outlier interval filter: valid/ready plus one kept interval.
// Depends on wof_pkg for field widths.
`timescale 1ns / 1ps

interface wof_out_if;
  import wof_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [START_W-1:0]      kept_start;
  logic [START_W-1:0]      kept_end;
  logic signed [LEN_W-1:0] kept_length;
  logic [NUM_W-1:0]        instance_number;
  logic                    run_last;

  modport source (output valid, output kept_start, output kept_end, output kept_length,
                  output instance_number, output run_last, input ready);
  modport sink   (input valid, input kept_start, input kept_end, input kept_length,
                  input instance_number, input run_last, output ready);
endinterface

[rtl/core/wof_window.sv]
// Neighbor window: pending and previous interval lengths with running sums.
// Issues at most one decision request per cycle while adv is high. Depends on wof_pkg.
`timescale 1ns / 1ps

module wof_window #(
  parameter int WindowHalf = wof_pkg::WINDOW_HALF_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        item_vld,
  input  logic [wof_pkg::START_W-1:0] item_start,
  input  logic [wof_pkg::START_W-1:0] item_end,
  input  logic [wof_pkg::SIZE_W-1:0]  item_size,
  input  logic                        item_last,
  output logic                        busy,
  output wof_pkg::req_t               req_r
);
  import wof_pkg::*;

  localparam int IDX_W = (WindowHalf > 1) ? $clog2(WindowHalf) : 1;
  localparam logic [CNT_W-1:0]  FULL   = CNT_W'(WindowHalf);
  localparam logic [SIZE_W-1:0] THRESH = SIZE_W'(DROP_FACTOR * WindowHalf);

  logic [START_W-1:0]      pend_start_r [WindowHalf];
  logic [START_W-1:0]      pend_end_r   [WindowHalf];
  logic signed [LEN_W-1:0] pend_len_r   [WindowHalf];
  logic signed [LEN_W-1:0] prev_len_r   [WindowHalf];
  logic [START_W-1:0]      pend_start_nxt [WindowHalf];
  logic [START_W-1:0]      pend_end_nxt   [WindowHalf];
  logic signed [LEN_W-1:0] pend_len_nxt   [WindowHalf];
  logic signed [LEN_W-1:0] prev_len_nxt   [WindowHalf];

  logic [CNT_W-1:0]        pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]        bcnt_r, bcnt_nxt;
  logic signed [SUM_W-1:0] psum_r, psum_nxt;
  logic signed [SUM_W-1:0] bsum_r, bsum_nxt;
  logic                    flush_r, flush_nxt;
  req_t                    req_nxt;

  logic signed [LEN_W-1:0] new_len;
  logic signed [SUM_W-1:0] new_len_x;
  logic signed [SUM_W-1:0] len0_x;
  logic signed [SUM_W-1:0] prev0_x;
  logic                    ok;
  logic                    decide;

  assign new_len   = $signed({2'b00, item_end}) - $signed({2'b00, item_start})
                     + LEN_W'(1);
  assign new_len_x = SUM_W'(new_len);
  assign len0_x    = SUM_W'(pend_len_r[0]);
  assign prev0_x   = SUM_W'(prev_len_r[0]);
  assign ok        = item_vld && (item_size >= THRESH);
  assign decide    = flush_r || (ok && (pcnt_r == FULL));
  assign busy      = flush_r;

  always_comb begin
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    pend_len_nxt   = pend_len_r;
    prev_len_nxt   = prev_len_r;
    pcnt_nxt       = pcnt_r;
    bcnt_nxt       = bcnt_r;
    psum_nxt       = psum_r;
    bsum_nxt       = bsum_r;
    flush_nxt      = flush_r;
    req_nxt        = '0;

    if (decide) begin
      // The oldest pending interval is judged against both neighbor sums.
      req_nxt.valid  = 1'b1;
      req_nxt.istart = pend_start_r[0];
      req_nxt.iend   = pend_end_r[0];
      req_nxt.len    = pend_len_r[0];
      req_nxt.bsum   = bsum_r;
      req_nxt.bcnt   = bcnt_r;
      if (flush_r) begin
        req_nxt.asum     = psum_r - len0_x;
        req_nxt.acnt     = pcnt_r - CNT_W'(1);
        req_nxt.step_end = (pcnt_r == CNT_W'(1));
      end else begin
        req_nxt.asum     = psum_r - len0_x + new_len_x;
        req_nxt.acnt     = FULL;
        req_nxt.step_end = !item_last;
      end

      // Retired length enters the previous window at the top.
      for (int i = 0; i < WindowHalf - 1; i++) begin
        prev_len_nxt[i] = prev_len_r[i+1];
      end
      prev_len_nxt[WindowHalf-1] = pend_len_r[0];
      if (bcnt_r == FULL) begin
        bsum_nxt = bsum_r + len0_x - prev0_x;
      end else begin
        bsum_nxt = bsum_r + len0_x;
        bcnt_nxt = bcnt_r + CNT_W'(1);
      end

      for (int i = 0; i < WindowHalf - 1; i++) begin
        pend_start_nxt[i] = pend_start_r[i+1];
        pend_end_nxt[i]   = pend_end_r[i+1];
        pend_len_nxt[i]   = pend_len_r[i+1];
      end

      if (flush_r) begin
        pcnt_nxt = pcnt_r - CNT_W'(1);
        psum_nxt = psum_r - len0_x;
        if (pcnt_r == CNT_W'(1)) begin
          flush_nxt = 1'b0;
          bcnt_nxt  = '0;
          bsum_nxt  = '0;
          psum_nxt  = '0;
        end
      end else begin
        pend_start_nxt[WindowHalf-1] = item_start;
        pend_end_nxt[WindowHalf-1]   = item_end;
        pend_len_nxt[WindowHalf-1]   = new_len;
        psum_nxt = psum_r - len0_x + new_len_x;
      end
    end else if (ok) begin
      pend_start_nxt[pcnt_r[IDX_W-1:0]] = item_start;
      pend_end_nxt[pcnt_r[IDX_W-1:0]]   = item_end;
      pend_len_nxt[pcnt_r[IDX_W-1:0]]   = new_len;
      pcnt_nxt = pcnt_r + CNT_W'(1);
      psum_nxt = psum_r + new_len_x;
    end

    // The last item of a group drains what is pending, or closes at once.
    if (item_vld && item_last) begin
      if (pcnt_nxt != '0) begin
        flush_nxt = 1'b1;
      end else begin
        bcnt_nxt = '0;
        bsum_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r  <= '0;
      bcnt_r  <= '0;
      psum_r  <= '0;
      bsum_r  <= '0;
      flush_r <= 1'b0;
      req_r   <= '0;
    end else if (adv) begin
      pcnt_r  <= pcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      psum_r  <= psum_nxt;
      bsum_r  <= bsum_nxt;
      flush_r <= flush_nxt;
      req_r   <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pend_start_r <= pend_start_nxt;
      pend_end_r   <= pend_end_nxt;
      pend_len_r   <= pend_len_nxt;
      prev_len_r   <= prev_len_nxt;
    end
  end

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r <= FULL) && (bcnt_r <= FULL))
    else $error("window count beyond its depth");

  a_flush_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (pcnt_r != '0))
    else $error("draining with nothing pending");

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && flush_r && (pcnt_r == CNT_W'(1))) |=>
      (!flush_r && (bcnt_r == '0) && (pcnt_r == '0)))
    else $error("group not closed after drain");

  a_decision_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_vld && !item_last && decide) |=> (req_r.valid && req_r.step_end))
    else $error("single decision not marked as end of beat group");

endmodule

[rtl/core/wof_judge.sv]
// Outlier test by cross-multiplication, instance numbering and last-result marking.
// A product register stage plus a one-result hold. Depends on wof_pkg.
`timescale 1ns / 1ps

module wof_judge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [wof_pkg::FACTOR_W-1:0] factor,
  input  wof_pkg::req_t                req,
  output logic                         push,
  output wof_pkg::res_t                push_data
);
  import wof_pkg::*;

  typedef struct packed {
    logic                     valid;
    logic                     step_end;
    logic [START_W-1:0]       istart;
    logic [START_W-1:0]       iend;
    logic signed [LEN_W-1:0]  len;
    logic                     bzero;
    logic                     azero;
    logic signed [PROD_W-1:0] lb;
    logic signed [PROD_W-1:0] fb;
    logic signed [PROD_W-1:0] la;
    logic signed [PROD_W-1:0] fa;
  } prod_t;

  prod_t              s2_r, s2_nxt;
  res_t               hold_r, hold_nxt;
  logic               hold_vld_r, hold_vld_nxt;
  logic               hold_fin_r, hold_fin_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;

  logic               ex_before;
  logic               ex_after;
  logic               d_keep;
  logic               d_close;

  always_comb begin
    s2_nxt          = '0;
    s2_nxt.valid    = req.valid;
    s2_nxt.step_end = req.step_end;
    s2_nxt.istart   = req.istart;
    s2_nxt.iend     = req.iend;
    s2_nxt.len      = req.len;
    s2_nxt.bzero    = (req.bcnt == '0);
    s2_nxt.azero    = (req.acnt == '0);
    s2_nxt.lb       = PROD_W'(req.len) * PROD_W'($signed({1'b0, req.bcnt}));
    s2_nxt.la       = PROD_W'(req.len) * PROD_W'($signed({1'b0, req.acnt}));
    s2_nxt.fb       = PROD_W'($signed({1'b0, factor})) * PROD_W'(req.bsum);
    s2_nxt.fa       = PROD_W'($signed({1'b0, factor})) * PROD_W'(req.asum);
  end

  // A side without neighbors has mean zero.
  assign ex_before = s2_r.bzero ? (s2_r.len > LEN_W'(0)) : (s2_r.lb > s2_r.fb);
  assign ex_after  = s2_r.azero ? (s2_r.len > LEN_W'(0)) : (s2_r.la > s2_r.fa);
  assign d_keep    = s2_r.valid && !(ex_before && ex_after);
  assign d_close   = s2_r.valid && !d_keep && s2_r.step_end;

  // The held result leaves once it is known whether a later kept result follows.
  assign push               = hold_vld_r && (hold_fin_r || d_keep || d_close);
  assign push_data          = '{kept_start:      hold_r.kept_start,
                                kept_end:        hold_r.kept_end,
                                kept_length:     hold_r.kept_length,
                                instance_number: hold_r.instance_number,
                                run_last:        hold_fin_r || d_close};

  always_comb begin
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    hold_fin_nxt = hold_fin_r;
    num_nxt      = num_r;
    if (d_keep) begin
      hold_nxt.kept_start      = s2_r.istart;
      hold_nxt.kept_end        = s2_r.iend;
      hold_nxt.kept_length     = s2_r.len;
      hold_nxt.instance_number = num_r;
      hold_nxt.run_last        = 1'b0;
      hold_vld_nxt             = 1'b1;
      hold_fin_nxt             = s2_r.step_end;
      num_nxt                  = num_r + NUM_W'(1);
    end else if (push) begin
      hold_vld_nxt = 1'b0;
      hold_fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r       <= '0;
      hold_vld_r <= 1'b0;
      hold_fin_r <= 1'b0;
      num_r      <= NUM_RESET;
    end else if (adv) begin
      s2_r       <= s2_nxt;
      hold_vld_r <= hold_vld_nxt;
      hold_fin_r <= hold_fin_nxt;
      num_r      <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

[rtl/core/wof_out_fifo.sv]
// Two-entry result queue that decouples the judge from the result channel.
// Depends on wof_pkg for the result type.
`timescale 1ns / 1ps

module wof_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wof_pkg::res_t push_data,
  output logic          full,
  output logic          vld,
  input  logic          pop,
  output wof_pkg::res_t pop_data
);
  import wof_pkg::*;

  res_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign vld      = (cnt_r != 2'd0);
  assign pop_data = mem_r[rptr_r];
  assign do_pop   = pop && vld;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/window_outlier_interval_filter_core.sv]
// Window outlier interval filter, top level. Throughput: one input beat per cycle.
// A result passes the window request, judge product and hold registers, then the result
// queue; at a group end a kept result may wait in the hold for the next kept or closing
// decision. group_last drains the pending intervals one per cycle while the queue has room,
// stalling input meanwhile; a full queue stalls every stage. Reset (rst_n, synchronous,
// active low) empties the window, sets outlier_factor to 10 and the instance number to 1.
`timescale 1ns / 1ps

module window_outlier_interval_filter_core #(
  parameter int WindowHalf = wof_pkg::WINDOW_HALF_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wof_in_if.sink                     in_ch,
  wof_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wof_pkg::ADDR_W-1:0] paddr,
  input  logic [wof_pkg::DATA_W-1:0] pwdata,
  output logic [wof_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import wof_pkg::*;

  // The pipeline has three parts. The window keeps the undecided intervals of the
  // current group and the lengths of the intervals just decided before them, together
  // with running sums of both, so every cycle it can hand one decision to the judge.
  // The judge forms the two cross products per side in one register stage and compares
  // them in the next. Because a group end can produce several kept results in a row,
  // the judge holds back each kept result by one decision to learn whether it is the
  // last one of its beat group. A two-entry queue then parts the pipeline from the
  // result channel; whenever it is full, every stage holds.

  logic [FACTOR_W-1:0] factor_r, factor_nxt;
  logic                cfg_wr;
  logic                cfg_hit;
  logic                adv;
  logic                busy;
  logic                item_vld;
  req_t                req;
  logic                push;
  res_t                push_data;
  logic                fifo_full;
  res_t                head;

  // Configuration writes are taken in the access phase; the block never waits.
  assign pready     = 1'b1;
  assign cfg_hit    = (paddr[ADDR_W-1:2] == REG_OUTLIER_FACTOR);
  assign cfg_wr     = psel && penable && pwrite && cfg_hit;
  assign factor_nxt = cfg_wr ? pwdata[FACTOR_W-1:0] : factor_r;
  assign prdata     = cfg_hit ? DATA_W'(factor_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else begin
      factor_r <= factor_nxt;
    end
  end

  // The whole pipeline advances together whenever the queue has room.
  assign adv         = !fifo_full;
  assign in_ch.ready = adv && !busy;
  assign item_vld    = in_ch.valid && in_ch.ready;

  wof_window #(
    .WindowHalf (WindowHalf)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_vld   (item_vld),
    .item_start (in_ch.interval_start),
    .item_end   (in_ch.interval_end),
    .item_size  (in_ch.group_size),
    .item_last  (in_ch.group_last),
    .busy       (busy),
    .req_r      (req)
  );

  wof_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .factor    (factor_r),
    .req       (req),
    .push      (push),
    .push_data (push_data)
  );

  wof_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push && adv),
    .push_data (push_data),
    .full      (fifo_full),
    .vld       (out_ch.valid),
    .pop       (out_ch.ready),
    .pop_data  (head)
  );

  assign out_ch.kept_start      = head.kept_start;
  assign out_ch.kept_end        = head.kept_end;
  assign out_ch.kept_length     = head.kept_length;
  assign out_ch.instance_number = head.instance_number;
  assign out_ch.run_last        = head.run_last;

endmodule
